[hw/rtl/pfe_pkg.sv]
// Shared types and constants for the postfix expression evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_MUL  = 3'd2;
  localparam op_t OP_DIV  = 3'd3;
  localparam op_t OP_POW  = 3'd4;
  localparam op_t OP_ZERO = 3'd5;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic fault;
  } alu_sts_t;

endpackage

[hw/rtl/pfe_alu.sv]
// Iterative arithmetic unit: add, subtract, multiply, divide and integer power.
`timescale 1ns / 1ps

module pfe_alu (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::alu_ctl_t ctl,
  input  logic [31:0]       lhs,
  input  logic [31:0]       rhs,
  output pfe_pkg::alu_sts_t sts,
  output logic [31:0]       result
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_DFIX = 2'd2;
  localparam logic [1:0] A_POW  = 2'd3;

  logic [1:0]  state;
  logic        done;
  logic        done_next;
  logic        fault;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [4:0]  cnt;
  logic [31:0] pacc;
  logic [31:0] psq;
  logic [30:0] pex;
  logic        phase;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [31:0] product;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] lhs_mag;
  logic [31:0] rhs_mag;

  // One shared multiplier serves plain multiply and both power steps
  always_comb begin
    if (state == A_POW && phase) begin
      mul_a = psq;
      mul_b = psq;
    end else if (state == A_POW) begin
      mul_a = pacc;
      mul_b = psq;
    end else begin
      mul_a = lhs;
      mul_b = rhs;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign product  = mul_full[31:0];

  // Restoring divide, one quotient bit a cycle
  assign trial   = {rem, quo[31]};
  assign ge      = trial >= {1'b0, dvs};
  assign diff    = trial - {1'b0, dvs};
  assign lhs_mag = lhs[31] ? (~lhs + 32'd1) : lhs;
  assign rhs_mag = rhs[31] ? (~rhs + 32'd1) : rhs;

  // Raise done on the edge that loads the result
  always_comb begin
    case (state)
      A_IDLE:  done_next = ctl.start &&
                           !((ctl.op == pfe_pkg::OP_DIV) && (rhs != 32'd0)) &&
                           !((ctl.op == pfe_pkg::OP_POW) && !rhs[31]);
      A_DFIX:  done_next = 1'b1;
      A_POW:   done_next = (pex == 31'd0);
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        A_IDLE: begin
          if (ctl.start) begin
            case (ctl.op)
              pfe_pkg::OP_ADD: begin
                result <= lhs + rhs;
                fault  <= 1'b0;
              end
              pfe_pkg::OP_SUB: begin
                result <= lhs - rhs;
                fault  <= 1'b0;
              end
              pfe_pkg::OP_MUL: begin
                result <= product;
                fault  <= 1'b0;
              end
              pfe_pkg::OP_DIV: begin
                if (rhs == 32'd0) begin
                  result <= 32'd0;
                  fault  <= 1'b1;
                end else begin
                  quo   <= lhs_mag;
                  dvs   <= rhs_mag;
                  rem   <= 32'd0;
                  neg   <= lhs[31] ^ rhs[31];
                  cnt   <= 5'd0;
                  state <= A_DIV;
                end
              end
              pfe_pkg::OP_POW: begin
                if (rhs[31]) begin
                  // negative exponent: truncated reciprocal
                  fault <= (lhs == 32'd0);
                  if (lhs == 32'd1) begin
                    result <= 32'd1;
                  end else if (lhs == 32'hFFFF_FFFF) begin
                    result <= rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                  end else begin
                    result <= 32'd0;
                  end
                end else begin
                  pacc  <= 32'd1;
                  psq   <= lhs;
                  pex   <= rhs[30:0];
                  phase <= 1'b0;
                  state <= A_POW;
                end
              end
              default: begin
                result <= 32'd0;
                fault  <= 1'b0;
              end
            endcase
          end
        end
        A_DIV: begin
          rem <= ge ? diff[31:0] : trial[31:0];
          quo <= {quo[30:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= A_DFIX;
          end
        end
        A_DFIX: begin
          result <= neg ? (~quo + 32'd1) : quo;
          fault  <= 1'b0;
          state  <= A_IDLE;
        end
        A_POW: begin
          // stop once no exponent bits remain
          if (pex == 31'd0) begin
            result <= pacc;
            fault  <= 1'b0;
            state  <= A_IDLE;
          end else if (!phase) begin
            if (pex[0]) begin
              pacc <= product;
            end
            phase <= 1'b1;
          end else begin
            psq   <= product;
            pex   <= pex >> 1;
            phase <= 1'b0;
          end
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign sts.done  = done;
  assign sts.fault = fault;

endmodule

[hw/rtl/postfix_expression_evaluator.sv]
// Top level of the postfix expression evaluator: sequencer, operand stack, result register.
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------
// input     | char_valid / char_ready    | char_code[7:0], end_of_text
// result    | result_valid / result_ready| value[31:0] signed, expr_ok, arith_fault
//
// Steps: a digit is taken in the idle state; any other word goes through S_END to
// close an open number, and an operator then pops right and left operands, starts
// the arithmetic unit and waits for it (/ divides bit-serially, ^ makes two multiplier
// passes per exponent bit). The last word adds a final pop and the emit. Reset empties
// the stack at once; stack entries are never read before written.
// char_ready is low while a word is in work; a held result stalls only the
// final emit, never the arithmetic.

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] value,
  output logic               expr_ok,
  output logic               arith_fault
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;  // take a word
  localparam logic [2:0] S_END  = 3'd1;  // push an open number
  localparam logic [2:0] S_POPR = 3'd2;  // pop right operand
  localparam logic [2:0] S_POPL = 3'd3;  // pop left operand
  localparam logic [2:0] S_OPST = 3'd4;  // launch arithmetic
  localparam logic [2:0] S_WAIT = 3'd5;  // wait, then push result
  localparam logic [2:0] S_FPOP = 3'd6;  // final pop
  localparam logic [2:0] S_EMIT = 3'd7;  // load result register

  logic [2:0]     state;
  logic [SPW-1:0] sp;
  logic [31:0]    acc;
  logic           in_number;
  logic           ok_flag;
  logic           fault_flag;
  logic           is_op;
  logic           fin;
  pfe_pkg::op_t   op;
  logic [31:0]    rhs;
  logic           under;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic           accept;
  logic           is_digit;
  logic           is_skip;
  logic [7:0]     digit;
  logic [31:0]    acc_next;
  logic           sp_empty;
  logic           sp_full;
  logic [SPW-1:0] sp_dec;
  logic           emit_fire;
  logic [31:0]    popped;

  pfe_pkg::alu_ctl_t alu_ctl;
  pfe_pkg::alu_sts_t alu_sts;
  logic [31:0]       alu_result;

  assign char_ready = (state == S_IDLE);
  assign accept     = char_valid && char_ready;

  assign is_digit = (char_code >= pfe_pkg::CH_ZERO) && (char_code <= pfe_pkg::CH_NINE);
  assign is_skip  = (char_code == pfe_pkg::CH_SPACE) || (char_code == pfe_pkg::CH_COMMA) ||
                    (char_code == pfe_pkg::CH_LPAREN) || (char_code == pfe_pkg::CH_RPAREN);
  assign digit    = char_code - pfe_pkg::CH_ZERO;
  // acc * 10 as two shifts, wrapping at 32 bits
  assign acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, digit[3:0]};

  assign sp_empty  = (sp == '0);
  assign sp_full   = (sp >= SPW'(STACK_DEPTH));
  assign sp_dec    = sp - SPW'(1);
  assign popped    = under ? 32'd0 : rd_data;
  assign emit_fire = (state == S_EMIT) && (!result_valid || result_ready);

  // Stack port control: one read and one write address per cycle
  assign rd_en   = ((state == S_POPR) || (state == S_POPL) || (state == S_FPOP)) && !sp_empty;
  assign rd_addr = sp_dec[AW-1:0];
  assign wr_en   = !sp_full && (((state == S_END) && in_number) ||
                                ((state == S_WAIT) && alu_sts.done));
  assign wr_addr = sp[AW-1:0];
  assign wr_data = (state == S_END) ? acc : alu_result;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  assign alu_ctl.start = (state == S_OPST);
  assign alu_ctl.op    = op;

  pfe_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .lhs    (popped),
    .rhs    (rhs),
    .sts    (alu_sts),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      acc          <= 32'd0;
      in_number    <= 1'b0;
      ok_flag      <= 1'b1;
      fault_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // raise on a new result, drop once the held one is taken
      if (emit_fire) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            fin <= end_of_text;
            if (is_digit) begin
              acc       <= acc_next;
              in_number <= 1'b1;
              is_op     <= 1'b0;
              state     <= end_of_text ? S_END : S_IDLE;
            end else begin
              is_op <= !is_skip;
              state <= S_END;
              case (char_code)
                pfe_pkg::CH_PLUS:  op <= pfe_pkg::OP_ADD;
                pfe_pkg::CH_MINUS: op <= pfe_pkg::OP_SUB;
                pfe_pkg::CH_STAR:  op <= pfe_pkg::OP_MUL;
                pfe_pkg::CH_SLASH: op <= pfe_pkg::OP_DIV;
                pfe_pkg::CH_CARET: op <= pfe_pkg::OP_POW;
                default: begin
                  op <= pfe_pkg::OP_ZERO;
                  if (!is_skip) begin
                    ok_flag <= 1'b0;
                  end
                end
              endcase
            end
          end
        end
        S_END: begin
          // end any open number: push it or flag overflow
          if (in_number) begin
            if (sp_full) begin
              fault_flag <= 1'b1;
            end else begin
              sp <= sp + SPW'(1);
            end
          end
          acc       <= 32'd0;
          in_number <= 1'b0;
          if (is_op) begin
            state <= S_POPR;
          end else if (fin) begin
            state <= S_FPOP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POPR: begin
          under <= sp_empty;
          if (sp_empty) begin
            fault_flag <= 1'b1;
          end else begin
            sp <= sp_dec;
          end
          state <= S_POPL;
        end
        S_POPL: begin
          rhs   <= popped;
          under <= sp_empty;
          if (sp_empty) begin
            fault_flag <= 1'b1;
          end else begin
            sp <= sp_dec;
          end
          state <= S_OPST;
        end
        S_OPST: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_sts.done) begin
            if (sp_full || alu_sts.fault) begin
              fault_flag <= 1'b1;
            end
            if (!sp_full) begin
              sp <= sp + SPW'(1);
            end
            state <= fin ? S_FPOP : S_IDLE;
          end
        end
        S_FPOP: begin
          under <= sp_empty;
          if (sp_empty) begin
            fault_flag <= 1'b1;
          end else begin
            sp <= sp_dec;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the result register is free, then clear the expression
          if (emit_fire) begin
            value        <= popped;
            expr_ok      <= ok_flag;
            arith_fault  <= fault_flag;
            sp           <= '0;
            acc          <= 32'd0;
            in_number    <= 1'b0;
            ok_flag      <= 1'b1;
            fault_flag   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_sts.done |-> (state == S_WAIT))
    else $error("arithmetic result arrived outside the wait state");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (sp == '0) && ok_flag && !fault_flag && !in_number)
    else $error("expression state not cleared after emit");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_EMIT))
    else $error("result raised outside the emit state");

endmodule

[sim/tb.sv]
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;
  localparam int ITEMS_PER_PHASE = 500;

  typedef struct {
    logic [31:0] value;
    logic        ok;
    logic        fault;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               char_valid = 1'b0;
  logic               char_ready;
  logic [7:0]         char_code = 8'h00;
  logic               end_of_text = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] value;
  logic               expr_ok;
  logic               arith_fault;

  // Idle and stall rates, in percent, for the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned words_sent = 0;
  int unsigned mismatch_count = 0;

  // Results the evaluator still owes, oldest first.
  eval_result_t results_due[$];

  // Mirror of the evaluator state.
  logic [31:0] mirror_stack [DEPTH];
  int unsigned mirror_sp;
  logic [31:0] mirror_num;
  bit          mirror_in_num;
  bit          mirror_ok;
  bit          mirror_fault;

  logic [7:0] op_chars [5] = '{pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS, pfe_pkg::CH_STAR,
                               pfe_pkg::CH_SLASH, pfe_pkg::CH_CARET};
  logic [7:0] sep_chars [4] = '{pfe_pkg::CH_SPACE, pfe_pkg::CH_COMMA, pfe_pkg::CH_LPAREN,
                                pfe_pkg::CH_RPAREN};
  logic [31:0] odd_values [6] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF};

  postfix_expression_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .value       (value),
    .expr_ok     (expr_ok),
    .arith_fault (arith_fault)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Evaluator mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_mirror();
    mirror_sp = 0;
    mirror_num = '0;
    mirror_in_num = 1'b0;
    mirror_ok = 1'b1;
    mirror_fault = 1'b0;
  endfunction

  // Drop the push and flag a fault once the stack is full.
  function automatic void push_operand(logic [31:0] v);
    if (mirror_sp < DEPTH) begin
      mirror_stack[mirror_sp] = v;
      mirror_sp++;
    end else begin
      mirror_fault = 1'b1;
    end
  endfunction

  // An empty stack reads as zero with a fault.
  function automatic logic [31:0] pop_operand();
    if (mirror_sp == 0) begin
      mirror_fault = 1'b1;
      return '0;
    end
    mirror_sp--;
    return mirror_stack[mirror_sp];
  endfunction

  function automatic void close_number();
    if (mirror_in_num) begin
      push_operand(mirror_num);
      mirror_num = '0;
      mirror_in_num = 1'b0;
    end
  endfunction

  // Signed quotient truncated toward zero; a zero divisor gives 0 and a fault.
  function automatic logic [31:0] signed_quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n, mag_d, q;
    if (den == '0) begin
      mirror_fault = 1'b1;
      return '0;
    end
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q = mag_n / mag_d;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  // Integer power, wrapping; a negative exponent behaves like a truncated
  // reciprocal, and a zero base with a negative exponent is a fault.
  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc, sq;
    if (ex[31]) begin
      if (base == 32'h1) return 32'h1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'h1;
      if (base == '0) mirror_fault = 1'b1;
      return '0;
    end
    acc = 32'h1;
    sq = base;
    for (int k = 0; k < 31; k++) begin
      if (ex[k]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  // Advance the mirror by one character; return 1 when it yields a result.
  function automatic bit eval_char(logic [7:0] c, bit last, output eval_result_t r);
    logic [31:0] rhs, lhs, res;
    r.value = '0;
    r.ok = 1'b0;
    r.fault = 1'b0;
    if (c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) begin
      mirror_num = mirror_num * 32'd10 + 32'(c - pfe_pkg::CH_ZERO);
      mirror_in_num = 1'b1;
    end else begin
      close_number();
      if (c != pfe_pkg::CH_SPACE && c != pfe_pkg::CH_COMMA &&
          c != pfe_pkg::CH_LPAREN && c != pfe_pkg::CH_RPAREN) begin
        rhs = pop_operand();
        lhs = pop_operand();
        case (c)
          pfe_pkg::CH_PLUS:  res = lhs + rhs;
          pfe_pkg::CH_MINUS: res = lhs - rhs;
          pfe_pkg::CH_STAR:  res = lhs * rhs;
          pfe_pkg::CH_SLASH: res = signed_quotient(lhs, rhs);
          pfe_pkg::CH_CARET: res = int_power(lhs, rhs);
          default: begin
            res = '0;
            mirror_ok = 1'b0;
          end
        endcase
        push_operand(res);
      end
    end
    if (!last) return 1'b0;
    close_number();
    r.value = pop_operand();
    r.ok = mirror_ok;
    r.fault = mirror_fault;
    clear_mirror();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one word. Entered and left at a rising edge; valid stays high on exit
  // so a back-to-back word keeps it high without a glitch.
  task automatic send_char(logic [7:0] c, bit last);
    int unsigned gap;
    eval_result_t r;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    end_of_text <= last;
    // Ready only moves at a rising edge, so the falling edge sees the value
    // that decides the next acceptance.
    do @(negedge clk); while (!char_ready);
    if (eval_char(c, last, r)) results_due.push_back(r);
    words_sent++;
    @(posedge clk);
  endtask

  task automatic send_text(const ref logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic test_drain_pause();
    char_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking, sampled mid-cycle where valid and ready are settled
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    eval_result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result value %0d ok %0b fault %0b", $time, value,
                 expr_ok, arith_fault);
        mismatch_count++;
      end else begin
        exp_r = results_due.pop_front();
        if (value !== exp_r.value) begin
          $display("%0t: value expected %0d actual %0d", $time, $signed(exp_r.value),
                   value);
          mismatch_count++;
        end
        if (expr_ok !== exp_r.ok) begin
          $display("%0t: expr_ok expected %0b actual %0b", $time, exp_r.ok, expr_ok);
          mismatch_count++;
        end
        if (arith_fault !== exp_r.fault) begin
          $display("%0t: arith_fault expected %0b actual %0b", $time, exp_r.fault,
                   arith_fault);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------

  function automatic void add_str(ref logic [7:0] txt[$], input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void add_sep(ref logic [7:0] txt[$]);
    txt.push_back(sep_chars[$urandom_range(3)]);
    if ($urandom_range(7) == 0) txt.push_back(sep_chars[$urandom_range(3)]);
  endfunction

  // Keep a new number from running into the previous one.
  function automatic void split_digits(ref logic [7:0] txt[$]);
    if (txt.size() != 0 && txt[$] >= pfe_pkg::CH_ZERO && txt[$] <= pfe_pkg::CH_NINE)
      add_sep(txt);
  endfunction

  // Append one operand; the negative form "0 k -" leaves one operand too.
  function automatic void add_operand(ref logic [7:0] txt[$]);
    int unsigned pick;
    split_digits(txt);
    pick = $urandom_range(99);
    if (pick < 40) begin
      add_str(txt, $sformatf("%0d", $urandom_range(20)));
    end else if (pick < 60) begin
      add_str(txt, $sformatf("%0d", odd_values[$urandom_range(5)]));
    end else if (pick < 78) begin
      add_str(txt, $sformatf("%0d", $urandom));
    end else if (pick < 88) begin
      // Long digit runs wrap the accumulator.
      repeat ($urandom_range(11, 15))
        txt.push_back(pfe_pkg::CH_ZERO + 8'($urandom_range(9)));
    end else begin
      txt.push_back(pfe_pkg::CH_ZERO);
      add_sep(txt);
      add_str(txt, $sformatf("%0d", $urandom_range(1, 40)));
      txt.push_back(pfe_pkg::CH_MINUS);
    end
  endfunction

  // A well-formed expression with random operands, operators and spacing.
  function automatic void build_wellformed(ref logic [7:0] txt[$]);
    int unsigned operands, pushed, depth;
    operands = $urandom_range(1, 6);
    pushed = 0;
    depth = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
        add_operand(txt);
        pushed++;
        depth++;
      end else begin
        txt.push_back(op_chars[$urandom_range(4)]);
        depth--;
        if ($urandom_range(2) == 0) add_sep(txt);
      end
    end
    if ($urandom_range(5) == 0) add_sep(txt);
  endfunction

  // Division and power on corner operands: most negative over minus one,
  // negative exponents, zero base, zero divisor.
  function automatic void build_corner(ref logic [7:0] txt[$]);
    logic [31:0] lhs, rhs;
    lhs = ($urandom_range(3) == 0) ? $urandom : odd_values[$urandom_range(5)];
    rhs = ($urandom_range(3) == 0) ? $urandom : odd_values[$urandom_range(5)];
    if ($urandom_range(1) == 0 && !rhs[31]) rhs = rhs | 32'h8000_0000;
    add_str(txt, $sformatf("%0d", lhs));
    add_sep(txt);
    add_str(txt, $sformatf("%0d", rhs));
    txt.push_back($urandom_range(1) ? pfe_pkg::CH_SLASH : pfe_pkg::CH_CARET);
  endfunction

  // Push past the stack depth, then fold part of it back.
  function automatic void build_deep(ref logic [7:0] txt[$]);
    repeat ($urandom_range(DEPTH - 3, DEPTH + 6)) begin
      txt.push_back(pfe_pkg::CH_ZERO + 8'($urandom_range(9)));
      txt.push_back(pfe_pkg::CH_SPACE);
    end
    repeat ($urandom_range(0, 4)) txt.push_back(op_chars[$urandom_range(4)]);
  endfunction

  // Arbitrary bytes, leaning toward characters the evaluator knows.
  function automatic void build_noise(ref logic [7:0] txt[$]);
    int unsigned pick;
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(3);
      if (pick == 0) txt.push_back(8'($urandom_range(255)));
      else if (pick == 1) txt.push_back(pfe_pkg::CH_ZERO + 8'($urandom_range(9)));
      else if (pick == 2) txt.push_back(op_chars[$urandom_range(4)]);
      else txt.push_back(sep_chars[$urandom_range(3)]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operator and the skipped characters comma and parentheses; ends on 2.
  task automatic test_all_operators();
    logic [7:0] txt[$];
    add_str(txt, "8,3-2*7/(2)^1+");
    send_text(txt);
  endtask

  // Empty expression underflows; a trailing digit is pushed before the pop.
  task automatic test_empty_and_trailing_digit();
    send_char(pfe_pkg::CH_SPACE, 1'b1);
    send_char(pfe_pkg::CH_NINE, 1'b1);
  endtask

  task automatic test_division_by_zero();
    logic [7:0] txt[$];
    add_str(txt, "5 0/");
    send_text(txt);
  endtask

  // Code extremes as unknown characters, on an empty stack.
  task automatic test_unknown_characters();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_random_expressions(int unsigned idle_pct, int unsigned stall_pct);
    logic [7:0] txt[$];
    int unsigned first, kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = words_sent;
    while (words_sent - first < ITEMS_PER_PHASE) begin
      txt.delete();
      kind = $urandom_range(99);
      if (kind < 58) begin
        build_wellformed(txt);
      end else if (kind < 70) begin
        build_corner(txt);
      end else if (kind < 74) begin
        build_deep(txt);
      end else if (kind < 84) begin
        // Broken sequence: drop a character or add a stray operator.
        build_wellformed(txt);
        if ($urandom_range(1) == 0 && txt.size() > 1) txt.delete($urandom_range(txt.size() - 1));
        else txt.push_back(op_chars[$urandom_range(4)]);
      end else begin
        build_noise(txt);
      end
      send_text(txt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_mirror();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_all_operators();
    test_empty_and_trailing_digit();
    test_division_by_zero();
    test_unknown_characters();

    test_random_expressions(0, 0);
    test_drain_pause();
    test_random_expressions(74, 0);
    test_drain_pause();
    test_random_expressions(0, 74);
    test_drain_pause();
    test_random_expressions(29, 29);

    char_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    // Leave room for a stray result after the last expected one.
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
